// ===== rtl/core/jbnc_pkg.sv =====
// Shared types and constants of the JSON bracket nesting checker.
package jbnc_pkg;

   // Field widths fixed by the request and response formats
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned OUT_W    = 24;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY_CLOSE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_MISMATCH    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_UNCLOSED    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 3'd4;

   // Characters of interest
   localparam logic [BYTE_W-1:0] CH_BRACE_OPEN    = 8'h7B;
   localparam logic [BYTE_W-1:0] CH_BRACKET_OPEN  = 8'h5B;
   localparam logic [BYTE_W-1:0] CH_BRACE_CLOSE   = 8'h7D;
   localparam logic [BYTE_W-1:0] CH_BRACKET_CLOSE = 8'h5D;
   localparam logic [BYTE_W-1:0] CH_QUOTE         = 8'h22;
   localparam logic [BYTE_W-1:0] CH_BACKSLASH     = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_NEWLINE       = 8'h0A;

   // Kind of an open nesting level
   localparam logic KIND_BRACE   = 1'b0;
   localparam logic KIND_BRACKET = 1'b1;

   // Stack operation from the scanner
   typedef struct packed {
      logic push;
      logic pop;
      logic kind;
      logic clear;
   } stack_op_type;

   // Stack condition seen by the scanner
   typedef struct packed {
      logic top_kind;
      logic empty;
      logic single;
      logic full;
   } stack_stat_type;

endpackage

// ===== rtl/core/json_bracket_nesting_checker_top.sv =====
// Top level of the JSON bracket nesting checker: request and response registers.
// Checks one JSON document byte by byte: braces and brackets must nest and match,
// anything inside double-quoted strings (and the byte after a backslash there)
// is ignored. Every request yields one response with a sticky status and the line
// and column of the first error, or the running position while all is well; a
// request with last_byte set also reports levels left open and returns the block
// to its reset state. One request is taken every clock cycle unless req_stall is
// high, and each request passes through the request register and then the
// response register, which presents its response; between the two lie the stack
// top compare and the saturating line and column increments. The stack is a
// MAX_DEPTH-bit shift register, so no clearing pass follows reset.
module json_bracket_nesting_checker_top #(
   parameter int unsigned MAX_DEPTH  = 64,
   parameter int unsigned COUNT_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [jbnc_pkg::BYTE_W-1:0]       req_byte_in,
   input  logic                              req_last_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [jbnc_pkg::STATUS_W-1:0]     rsp_status,
   output logic [jbnc_pkg::OUT_W-1:0]        rsp_error_line,
   output logic [jbnc_pkg::OUT_W-1:0]        rsp_error_column,
   output logic                              rsp_done_res
);

   logic                          in_valid_ff;
   logic [jbnc_pkg::BYTE_W-1:0]   in_byte_ff;
   logic                          in_last_ff;
   logic                          out_valid_ff;
   logic [jbnc_pkg::STATUS_W-1:0] out_status_ff;
   logic [jbnc_pkg::OUT_W-1:0]    out_line_ff;
   logic [jbnc_pkg::OUT_W-1:0]    out_col_ff;
   logic                          out_done_ff;

   logic                          out_free, fire, req_take;
   jbnc_pkg::stack_op_type        op;
   jbnc_pkg::stack_stat_type      stat;
   logic [jbnc_pkg::STATUS_W-1:0] status;
   logic [jbnc_pkg::OUT_W-1:0]    error_line, error_column;

   // Advance when the response register is empty or being drained
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // Hold the request until it moves to the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take || fire) begin
         in_valid_ff <= req_take;
      end
      if (req_take) begin
         in_byte_ff <= req_byte_in;
         in_last_ff <= req_last_byte;
      end
   end

   jbnc_stack #(
      .MAX_DEPTH(MAX_DEPTH)
   ) u_stack (
      .clock(clock),
      .reset(reset),
      .op   (op),
      .stat (stat)
   );

   jbnc_scanner #(
      .COUNT_BITS(COUNT_BITS)
   ) u_scanner (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .byte_in     (in_byte_ff),
      .last_byte   (in_last_ff),
      .stat        (stat),
      .op          (op),
      .status      (status),
      .error_line  (error_line),
      .error_column(error_column)
   );

   // Load the response register, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= fire;
      end
      if (fire) begin
         out_status_ff <= status;
         out_line_ff   <= error_line;
         out_col_ff    <= error_column;
         out_done_ff   <= in_last_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_error_line   = out_line_ff;
   assign rsp_error_column = out_col_ff;
   assign rsp_done_res     = out_done_ff;

endmodule

// ===== rtl/core/jbnc_stack.sv =====
// Open-kind stack held as a shift register with a level counter.
module jbnc_stack #(
   parameter int unsigned MAX_DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  jbnc_pkg::stack_op_type   op,
   output jbnc_pkg::stack_stat_type stat
);

   localparam int unsigned LVL_W = $clog2(MAX_DEPTH + 1);

   logic [MAX_DEPTH-1:0] entries_ff;
   logic [MAX_DEPTH-1:0] entries_in;
   logic [LVL_W-1:0]     level_ff;
   logic [LVL_W-1:0]     level_in;

   // Shift entries away from the top on push, toward it on pop
   always_comb begin
      entries_in = entries_ff;
      level_in   = level_ff;
      if (op.push) begin
         entries_in = {entries_ff[MAX_DEPTH-2:0], op.kind};
         level_in   = level_ff + LVL_W'(1);
      end else if (op.pop) begin
         entries_in = entries_ff >> 1;
         level_in   = level_ff - LVL_W'(1);
      end
      if (op.clear) begin
         level_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
   end

   // Report top entry and fill condition
   assign stat.top_kind = entries_ff[0];
   assign stat.empty    = (level_ff == '0);
   assign stat.single   = (level_ff == LVL_W'(1));
   assign stat.full     = (level_ff == LVL_W'(MAX_DEPTH));

   a_no_push_pop: assert property (@(posedge clock) disable iff (reset)
      !(op.push && op.pop))
      else $error("stack push and pop in the same cycle");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LVL_W'(MAX_DEPTH))
      else $error("stack level beyond depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      op.push |-> !stat.full)
      else $error("push on full stack");

   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      op.clear |=> stat.empty)
      else $error("stack not empty after clear");

endmodule

// ===== rtl/core/jbnc_scanner.sv =====
// Byte scanner: string and escape tracking, counters, first-error latch.
module jbnc_scanner #(
   parameter int unsigned COUNT_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              fire,
   input  logic [jbnc_pkg::BYTE_W-1:0]       byte_in,
   input  logic                              last_byte,
   input  jbnc_pkg::stack_stat_type          stat,
   output jbnc_pkg::stack_op_type            op,
   output logic [jbnc_pkg::STATUS_W-1:0]     status,
   output logic [jbnc_pkg::OUT_W-1:0]        error_line,
   output logic [jbnc_pkg::OUT_W-1:0]        error_column
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic                          in_string_ff, in_string_in;
   logic                          skip_ff, skip_in;
   logic [COUNT_BITS-1:0]         line_ff, line_in;
   logic [COUNT_BITS-1:0]         col_ff, col_in;
   logic [jbnc_pkg::STATUS_W-1:0] sticky_ff, sticky_in;
   logic [COUNT_BITS-1:0]         lat_line_ff, lat_line_in;
   logic [COUNT_BITS-1:0]         lat_col_ff, lat_col_in;

   logic [COUNT_BITS-1:0]         line_step, col_step;
   logic [jbnc_pkg::STATUS_W-1:0] err_code;
   logic                          is_open, is_close, want_kind, empty_after;
   logic [31:0]                   line_wide, col_wide;

   assign is_open   = (byte_in == jbnc_pkg::CH_BRACE_OPEN) ||
                      (byte_in == jbnc_pkg::CH_BRACKET_OPEN);
   assign is_close  = (byte_in == jbnc_pkg::CH_BRACE_CLOSE) ||
                      (byte_in == jbnc_pkg::CH_BRACKET_CLOSE);
   assign want_kind = (byte_in == jbnc_pkg::CH_BRACKET_CLOSE) ?
                      jbnc_pkg::KIND_BRACKET : jbnc_pkg::KIND_BRACE;

   // Classify the byte and step counters and flags
   always_comb begin
      line_step    = line_ff;
      col_step     = col_ff;
      in_string_in = in_string_ff;
      skip_in      = skip_ff;
      err_code     = jbnc_pkg::ST_OK;
      op.push      = 1'b0;
      op.pop       = 1'b0;
      op.clear     = 1'b0;
      op.kind      = (byte_in == jbnc_pkg::CH_BRACKET_OPEN) ?
                     jbnc_pkg::KIND_BRACKET : jbnc_pkg::KIND_BRACE;
      if (fire) begin
         if (skip_ff) begin
            skip_in  = 1'b0;
            col_step = (col_ff == COUNT_MAX) ? col_ff : col_ff + COUNT_BITS'(1);
         end else if (byte_in == jbnc_pkg::CH_NEWLINE) begin
            line_step = (line_ff == COUNT_MAX) ? line_ff : line_ff + COUNT_BITS'(1);
            col_step  = '0;
         end else begin
            if (in_string_ff && (byte_in == jbnc_pkg::CH_BACKSLASH)) begin
               skip_in = 1'b1;
            end else if (byte_in == jbnc_pkg::CH_QUOTE) begin
               in_string_in = !in_string_ff;
            end else if (!in_string_ff && is_open) begin
               if (stat.full) begin
                  err_code = jbnc_pkg::ST_OVERFLOW;
               end else begin
                  op.push = 1'b1;
               end
            end else if (!in_string_ff && is_close) begin
               if (stat.empty) begin
                  err_code = jbnc_pkg::ST_EMPTY_CLOSE;
               end else if (stat.top_kind != want_kind) begin
                  err_code = jbnc_pkg::ST_MISMATCH;
               end else begin
                  op.pop = 1'b1;
               end
            end
            col_step = (col_ff == COUNT_MAX) ? col_ff : col_ff + COUNT_BITS'(1);
         end
         op.clear = last_byte;
      end
   end

   assign empty_after = stat.empty ? !op.push : (stat.single && op.pop);

   // Latch the first error, then the unclosed check at the last byte
   always_comb begin
      status      = sticky_ff;
      lat_line_in = lat_line_ff;
      lat_col_in  = lat_col_ff;
      if ((sticky_ff == jbnc_pkg::ST_OK) && (err_code != jbnc_pkg::ST_OK)) begin
         status      = err_code;
         lat_line_in = line_ff;
         lat_col_in  = col_ff;
      end
      if (last_byte && !empty_after && (status == jbnc_pkg::ST_OK)) begin
         status      = jbnc_pkg::ST_UNCLOSED;
         lat_line_in = line_step;
         lat_col_in  = col_step;
      end
   end

   // Pick latched or running position and clamp to the output width
   always_comb begin
      if (status != jbnc_pkg::ST_OK) begin
         line_wide = 32'(lat_line_in);
         col_wide  = 32'(lat_col_in);
      end else begin
         line_wide = 32'(line_step);
         col_wide  = 32'(col_step);
      end
      error_line   = (line_wide > 32'h00FF_FFFF) ? '1 : line_wide[jbnc_pkg::OUT_W-1:0];
      error_column = (col_wide > 32'h00FF_FFFF) ? '1 : col_wide[jbnc_pkg::OUT_W-1:0];
   end

   // Return to reset values after the last byte
   always_comb begin
      sticky_in = status;
      line_in   = line_step;
      col_in    = col_step;
      if (fire && last_byte) begin
         sticky_in    = jbnc_pkg::ST_OK;
         line_in      = '0;
         col_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_string_ff <= 1'b0;
         skip_ff      <= 1'b0;
         line_ff      <= '0;
         col_ff       <= '0;
         sticky_ff    <= jbnc_pkg::ST_OK;
         lat_line_ff  <= '0;
         lat_col_ff   <= '0;
      end else if (fire) begin
         in_string_ff <= last_byte ? 1'b0 : in_string_in;
         skip_ff      <= last_byte ? 1'b0 : skip_in;
         line_ff      <= line_in;
         col_ff       <= col_in;
         sticky_ff    <= sticky_in;
         lat_line_ff  <= last_byte ? '0 : lat_line_in;
         lat_col_ff   <= last_byte ? '0 : lat_col_in;
      end
   end

endmodule
